/* design/cfb_pkg.sv */
// Shared constants, step codes and the byte-wide CRC-32 update for the frame builder.
// No dependencies.
package cfb_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CRC_W  = 32;
    localparam int unsigned STEP_W = 3;

    localparam logic [CRC_W-1:0] CRC_INIT      = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] CRC_POLY_REFL = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_XOROUT    = 32'hFFFF_FFFF;

    localparam logic [BYTE_W-1:0] MSG_TYPE_RESET = 8'h00;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step ST_TYPE = 3'd0;
    localparam t_step ST_TXN  = 3'd1;
    localparam t_step ST_DATA = 3'd2;
    localparam t_step ST_CRC3 = 3'd3;
    localparam t_step ST_CRC2 = 3'd4;
    localparam t_step ST_CRC1 = 3'd5;
    localparam t_step ST_CRC0 = 3'd6;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* design/cfb_if.sv */
// Valid/ready channel interfaces for the frame builder: input, output and config.
// Depends on cfb_pkg.
interface cfb_in_if import cfb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              last_byte;
    logic              empty_item;

    modport source (output valid, payload_byte, last_byte, empty_item, input ready);
    modport sink   (input valid, payload_byte, last_byte, empty_item, output ready);
endinterface

interface cfb_out_if import cfb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_end;

    modport source (output valid, frame_byte, frame_end, input ready);
    modport sink   (input valid, frame_byte, frame_end, output ready);
endinterface

interface cfb_cfg_if import cfb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] msg_type;

    modport source (output valid, msg_type, input ready);
    modport sink   (input valid, msg_type, output ready);
endinterface

/* design/crc32_frame_builder.sv */
// Top level of the CRC-32 frame builder: item register, byte sequencer and output register.
// Depends on cfb_pkg and the channel interfaces in cfb_if.sv.
//
// Channels: i_in_ch carries payload items (payload_byte, last_byte, empty_item),
// o_out_ch carries frame beats (frame_byte, frame_end), i_cfg_ch writes the
// message type byte and is always ready.
// A frame opens with the type byte and the transaction number, carries one
// beat per non-empty payload item and closes with the four CRC bytes, most
// significant first; frame_end marks the last CRC beat.
// An accepted item is registered in the item and step registers; its first beat
// is then loaded into the output register when the sequencer advances.
// Throughput: one output beat per cycle while the receiver is ready, set by
// the single output register. A non-empty item inside an open frame gives one
// beat, so items stream at one per cycle unless stalled; the item that opens a
// frame is led by the type and transaction number beats, the one that closes it trails the CRC beats.
// Reset clears the transaction number to zero, the type byte to zero and
// closes any frame; the first frame carries transaction number 1.
// When the receiver stalls, the output beat holds and the sequencer waits;
// one item is held in the item register, after which input ready drops.
module crc32_frame_builder import cfb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cfb_in_if.sink    i_in_ch,
    cfb_cfg_if.sink   i_cfg_ch,
    cfb_out_if.source o_out_ch
);

    logic              r_busy;
    t_step             r_step;
    logic [BYTE_W-1:0] r_payload;
    logic              r_last;
    logic              r_empty;
    logic [BYTE_W-1:0] r_txn;
    logic [CRC_W-1:0]  r_crc;
    logic              r_inside;
    logic [BYTE_W-1:0] r_msg_type;
    logic              r_out_valid;
    logic [BYTE_W-1:0] r_out_byte;
    logic              r_out_end;

    logic              load_out;
    logic              adv;
    logic              finishing;
    logic              accept;
    logic [BYTE_W-1:0] emit_byte;
    logic              emit_end;
    logic [CRC_W-1:0]  crc_out;
    logic [CRC_W-1:0]  n_crc;
    logic [BYTE_W-1:0] n_txn;
    logic              n_inside;
    logic              has_next;
    t_step             nxt_step;
    logic              inside_now;
    logic              start_busy;
    t_step             start_step;

    assign load_out  = !r_out_valid || o_out_ch.ready;
    assign adv       = r_busy && load_out;
    assign finishing = adv && !has_next;
    assign accept    = i_in_ch.valid && i_in_ch.ready;
    assign crc_out   = r_crc ^ CRC_XOROUT;

    assign i_in_ch.ready  = !r_busy || finishing;
    assign i_cfg_ch.ready = 1'b1;

    assign o_out_ch.valid      = r_out_valid;
    assign o_out_ch.frame_byte = r_out_byte;
    assign o_out_ch.frame_end  = r_out_end;

    always_comb begin
        emit_byte = '0;
        emit_end  = 1'b0;
        n_crc     = r_crc;
        n_txn     = r_txn;
        n_inside  = r_inside;
        has_next  = 1'b0;
        nxt_step  = ST_TYPE;
        case (r_step)
            ST_TYPE: begin
                emit_byte = r_msg_type;
                n_txn     = r_txn + BYTE_W'(1);
                n_crc     = crc_byte(CRC_INIT, r_msg_type);
                n_inside  = 1'b1;
                has_next  = 1'b1;
                nxt_step  = ST_TXN;
            end
            ST_TXN: begin
                emit_byte = r_txn;
                n_crc     = crc_byte(r_crc, r_txn);
                has_next  = !r_empty || r_last;
                nxt_step  = !r_empty ? ST_DATA : ST_CRC3;
            end
            ST_DATA: begin
                emit_byte = r_payload;
                n_crc     = crc_byte(r_crc, r_payload);
                has_next  = r_last;
                nxt_step  = ST_CRC3;
            end
            ST_CRC3: begin
                emit_byte = crc_out[31:24];
                has_next  = 1'b1;
                nxt_step  = ST_CRC2;
            end
            ST_CRC2: begin
                emit_byte = crc_out[23:16];
                has_next  = 1'b1;
                nxt_step  = ST_CRC1;
            end
            ST_CRC1: begin
                emit_byte = crc_out[15:8];
                has_next  = 1'b1;
                nxt_step  = ST_CRC0;
            end
            ST_CRC0: begin
                emit_byte = crc_out[7:0];
                emit_end  = 1'b1;
                n_crc     = CRC_INIT;
                n_inside  = 1'b0;
            end
            default: begin
                emit_byte = '0;
            end
        endcase
    end

    always_comb begin
        inside_now = adv ? n_inside : r_inside;
        start_busy = 1'b1;
        start_step = ST_TYPE;
        if (!inside_now) begin
            start_step = ST_TYPE;
        end else if (!i_in_ch.empty_item) begin
            start_step = ST_DATA;
        end else if (i_in_ch.last_byte) begin
            start_step = ST_CRC3;
        end else begin
            start_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= ST_TYPE;
            r_txn       <= '0;
            r_crc       <= CRC_INIT;
            r_inside    <= 1'b0;
            r_msg_type  <= MSG_TYPE_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_ch.valid) begin
                r_msg_type <= i_cfg_ch.msg_type;
            end
            if (adv) begin
                r_crc    <= n_crc;
                r_txn    <= n_txn;
                r_inside <= n_inside;
            end
            if (accept) begin
                r_busy <= start_busy;
                r_step <= start_step;
            end else if (adv) begin
                r_busy <= has_next;
                r_step <= nxt_step;
            end
            if (load_out) begin
                r_out_valid <= adv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_payload <= i_in_ch.payload_byte;
            r_last    <= i_in_ch.last_byte;
            r_empty   <= i_in_ch.empty_item;
        end
        if (adv) begin
            r_out_byte <= emit_byte;
            r_out_end  <= emit_end;
        end
    end

endmodule
